@@ design/ptc_pkg.sv @@
// Package for the pressure/temperature compensation block.
// Holds the word structs, register indexes and shared helpers; no dependencies.
`timescale 1ns / 1ps
package ptc_pkg;

   localparam int unsigned DivBits = 32;

   typedef enum logic [1:0] {
      CSR_TEMP_COEFFS   = 2'd0,
      CSR_PRESS_LOW     = 2'd1,
      CSR_PRESS_HIGH    = 2'd2,
      CSR_PRESS_NINE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] press_msb;
      logic [7:0] press_lsb;
      logic [7:0] press_xlsb;
      logic [7:0] temp_msb;
      logic [7:0] temp_lsb;
      logic [7:0] temp_xlsb;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] temperature_centideg;
      logic [31:0]        pressure_pa;
      logic               pressure_invalid;
   } rsp_word_type;

   typedef struct packed {
      logic [47:0] temp_coeffs;
      logic [63:0] press_low;
      logic [63:0] press_high;
      logic [15:0] press_nine;
   } coeff_type;

   // Divider front end hands this to the divider and carries it along.
   typedef struct packed {
      logic        valid;
      logic [31:0] dividend;
      logic [31:0] divisor;
      logic        post_double;
      logic        invalid;
      logic [31:0] temp;
   } div_ctl_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      asr = 32'($signed(x) >>> n);
   endfunction

endpackage

@@ design/ptc_front.sv @@
// Front pipeline: raw assembly, temperature compensation and the divisor/dividend terms.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ptc_pkg::req_word_type in_word,
   input  ptc_pkg::coeff_type    coeffs,
   output ptc_pkg::div_ctl_type  out_ctl
);

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
   assign t1 = {16'd0, coeffs.temp_coeffs[15:0]};
   assign t2 = ptc_pkg::sx16(coeffs.temp_coeffs[31:16]);
   assign t3 = ptc_pkg::sx16(coeffs.temp_coeffs[47:32]);
   assign p1 = {16'd0, coeffs.press_low[15:0]};
   assign p2 = ptc_pkg::sx16(coeffs.press_low[31:16]);
   assign p3 = ptc_pkg::sx16(coeffs.press_low[47:32]);
   assign p4 = ptc_pkg::sx16(coeffs.press_low[63:48]);
   assign p5 = ptc_pkg::sx16(coeffs.press_high[15:0]);
   assign p6 = ptc_pkg::sx16(coeffs.press_high[31:16]);

   // Stage 1: raw values and first products.
   logic        v1_ff;
   logic [19:0] up1_ff;
   logic [31:0] ta1_ff, dd1_ff;
   logic [19:0] ut, up;
   logic [31:0] dt;
   assign ut = {in_word.temp_msb, in_word.temp_lsb, in_word.temp_xlsb[7:4]};
   assign up = {in_word.press_msb, in_word.press_lsb, in_word.press_xlsb[7:4]};
   assign dt = {16'd0, ut[19:4]} - t1;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      up1_ff <= up;
      ta1_ff <= 32'(({15'd0, ut[19:3]} - (t1 << 1)) * t2);
      dd1_ff <= 32'(dt * dt);
   end

   // Stage 2: second temperature product.
   logic        v2_ff;
   logic [19:0] up2_ff;
   logic [31:0] ta2_ff, tb2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      up2_ff <= up1_ff;
      ta2_ff <= ptc_pkg::asr(ta1_ff, 11);
      tb2_ff <= 32'(ptc_pkg::asr(dd1_ff, 12) * t3);
   end

   // Stage 3: fine temperature.
   logic        v3_ff;
   logic [19:0] up3_ff;
   logic [31:0] fine3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      up3_ff <= up2_ff;
      fine3_ff <= ta2_ff + ptc_pkg::asr(tb2_ff, 14);
   end

   // Stage 4: temperature result and pressure products.
   logic [31:0] pa, pq;
   assign pa = ptc_pkg::asr(fine3_ff, 1) - 32'd64000;
   assign pq = ptc_pkg::asr(pa, 2);
   logic        v4_ff;
   logic [19:0] up4_ff;
   logic [31:0] temp4_ff, qq4_ff, ap5_ff, ap2_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      up4_ff <= up3_ff;
      temp4_ff <= ptc_pkg::asr(32'(fine3_ff * 32'd5) + 32'd128, 8);
      qq4_ff <= 32'(pq * pq);
      ap5_ff <= 32'(pa * p5);
      ap2_ff <= 32'(p2 * pa);
   end

   // Stage 5: second-level products.
   logic        v5_ff;
   logic [19:0] up5_ff;
   logic [31:0] temp5_ff, b5_ff, a5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      up5_ff <= up4_ff;
      temp5_ff <= temp4_ff;
      b5_ff <= 32'(ptc_pkg::asr(qq4_ff, 11) * p6) + (ap5_ff << 1);
      a5_ff <= ptc_pkg::asr(ptc_pkg::asr(32'(p3 * ptc_pkg::asr(qq4_ff, 13)), 3)
               + ptc_pkg::asr(ap2_ff, 1), 18);
   end

   // Stage 6: divisor product and dividend offset.
   logic        v6_ff;
   logic [31:0] temp6_ff, div6_ff, off6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
      temp6_ff <= temp5_ff;
      div6_ff <= 32'((32'd32768 + a5_ff) * p1);
      off6_ff <= 32'd1048576 - {12'd0, up5_ff}
                 - ptc_pkg::asr(ptc_pkg::asr(b5_ff, 2) + (p4 << 16), 12);
   end

   // Stage 7: scaled dividend and divisor.
   logic [31:0] divisor, pv;
   assign divisor = ptc_pkg::asr(div6_ff, 15);
   assign pv = 32'(off6_ff * 32'd3125);
   ptc_pkg::div_ctl_type ctl7_ff;
   always_ff @(posedge clock) begin
      if (reset) ctl7_ff.valid <= 1'b0;
      else ctl7_ff.valid <= v6_ff;
      ctl7_ff.dividend    <= pv[31] ? pv : (pv << 1);
      ctl7_ff.post_double <= pv[31];
      ctl7_ff.divisor     <= divisor;
      ctl7_ff.invalid     <= (divisor == 32'd0);
      ctl7_ff.temp        <= temp6_ff;
   end

   assign out_ctl = ctl7_ff;

endmodule

@@ design/ptc_divider.sv @@
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ptc_pkg::div_ctl_type in_ctl,
   output ptc_pkg::div_ctl_type out_ctl,
   output logic [31:0]          quotient
);

   localparam int unsigned N = ptc_pkg::DivBits;

   ptc_pkg::div_ctl_type ctl_ff [N];
   logic [31:0]          rem_ff [N];
   logic [31:0]          quo_ff [N];

   for (genvar s = 0; s < N; s++) begin : g_stage
      ptc_pkg::div_ctl_type c_in;
      logic [31:0]          r_in, q_in;
      logic [32:0]          trial;
      if (s == 0) begin : g_first
         assign c_in = in_ctl;
         assign r_in = 32'd0;
         assign q_in = in_ctl.dividend;
      end else begin : g_next
         assign c_in = ctl_ff[s-1];
         assign r_in = rem_ff[s-1];
         assign q_in = quo_ff[s-1];
      end
      assign trial = {r_in, q_in[31]} - {1'b0, c_in.divisor};
      always_ff @(posedge clock) begin
         if (reset) ctl_ff[s].valid <= 1'b0;
         else ctl_ff[s].valid <= c_in.valid;
         ctl_ff[s].dividend    <= c_in.dividend;
         ctl_ff[s].divisor     <= c_in.divisor;
         ctl_ff[s].post_double <= c_in.post_double;
         ctl_ff[s].invalid     <= c_in.invalid;
         ctl_ff[s].temp        <= c_in.temp;
         if (!trial[32]) begin
            rem_ff[s] <= trial[31:0];
            quo_ff[s] <= {q_in[30:0], 1'b1};
         end else begin
            rem_ff[s] <= {r_in[30:0], q_in[31]};
            quo_ff[s] <= {q_in[30:0], 1'b0};
         end
      end
   end

   assign out_ctl  = ctl_ff[N-1];
   assign quotient = quo_ff[N-1];

endmodule

@@ design/ptc_back.sv @@
// Back pipeline: final pressure correction with p7..p9 and the result register.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
module ptc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ptc_pkg::div_ctl_type in_ctl,
   input  logic [31:0]          quotient,
   input  ptc_pkg::coeff_type   coeffs,
   output logic                 out_valid,
   output ptc_pkg::rsp_word_type out_word
);

   logic [31:0] p7, p8, p9;
   assign p7 = ptc_pkg::sx16(coeffs.press_high[47:32]);
   assign p8 = ptc_pkg::sx16(coeffs.press_high[63:48]);
   assign p9 = ptc_pkg::sx16(coeffs.press_nine);

   // Stage 1: undo scaling, square term.
   logic [31:0] pd;
   assign pd = in_ctl.post_double ? (quotient << 1) : quotient;
   logic        v1_ff, inv1_ff;
   logic [31:0] p1_ff, t1_ff, sq1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_ctl.valid;
      inv1_ff <= in_ctl.invalid;
      t1_ff   <= in_ctl.temp;
      p1_ff   <= pd;
      sq1_ff  <= 32'((pd >> 3) * (pd >> 3));
   end

   // Stage 2: coefficient products.
   logic        v2_ff, inv2_ff;
   logic [31:0] p2_ff, t2_ff, a2_ff, b2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      inv2_ff <= inv1_ff;
      t2_ff   <= t1_ff;
      p2_ff   <= p1_ff;
      a2_ff   <= 32'(p9 * (sq1_ff >> 13));
      b2_ff   <= 32'((p1_ff >> 2) * p8);
   end

   // Stage 3: result register.
   logic        v3_ff;
   ptc_pkg::rsp_word_type w3_ff;
   logic [31:0] corr;
   assign corr = ptc_pkg::asr(ptc_pkg::asr(a2_ff, 12) + ptc_pkg::asr(b2_ff, 13) + p7, 4);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      w3_ff.temperature_centideg <= t2_ff;
      w3_ff.pressure_pa          <= inv2_ff ? 32'd0 : p2_ff + corr;
      w3_ff.pressure_invalid     <= inv2_ff;
   end

   assign out_valid = v3_ff;
   assign out_word  = w3_ff;

endmodule

@@ design/pressure_temp_compensation.sv @@
// Top level of the pressure/temperature compensation block.
// Depends on ptc_pkg, ptc_front, ptc_divider and ptc_back.
//
//   channel | ports                          | handshake
//   request | req_start, req_busy, req_word  | accepted when start and not busy
//   result  | rsp_strobe, rsp_word           | one cycle per word, no back pressure
//   config  | csr_valid, csr_ready, csr_*    | written when valid and ready
//
// One word enters every cycle; each result passes through the seven front stages,
// the 32-stage divider and the three back stages in order.
// Reset is synchronous and clears all valid bits; coefficients reset to zero.
// busy is always low and csr_ready always high since nothing can stall.
`timescale 1ns / 1ps
module pressure_temp_compensation (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   output logic                   req_busy,
   input  ptc_pkg::req_word_type  req_word,
   output logic                   rsp_strobe,
   output ptc_pkg::rsp_word_type  rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_data
);

   ptc_pkg::coeff_type coeffs_ff;

   assign req_busy  = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeffs_ff <= '0;
      end else if (csr_valid) begin
         case (ptc_pkg::csr_index_type'(csr_index))
            ptc_pkg::CSR_TEMP_COEFFS: coeffs_ff.temp_coeffs <= csr_data[47:0];
            ptc_pkg::CSR_PRESS_LOW:   coeffs_ff.press_low   <= csr_data;
            ptc_pkg::CSR_PRESS_HIGH:  coeffs_ff.press_high  <= csr_data;
            ptc_pkg::CSR_PRESS_NINE:  coeffs_ff.press_nine  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   ptc_pkg::div_ctl_type front_ctl, div_ctl;
   logic [31:0]          quotient;

   ptc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_start & ~req_busy),
      .in_word (req_word),
      .coeffs  (coeffs_ff),
      .out_ctl (front_ctl)
   );

   ptc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (front_ctl),
      .out_ctl (div_ctl),
      .quotient(quotient)
   );

   ptc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (div_ctl),
      .quotient (quotient),
      .coeffs   (coeffs_ff),
      .out_valid(rsp_strobe),
      .out_word (rsp_word)
   );

   // A zero divisor always yields zero pressure.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.pressure_invalid |-> rsp_word.pressure_pa == 32'd0)
      else $error("invalid pressure is not zero");

   // A word accepted now produces a result once it has passed the whole pipeline.
   assert property (@(posedge clock) disable iff (reset)
      req_start |-> ##42 rsp_strobe)
      else $error("result missing after latency");

   // No result without a word that entered the pipeline earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_start, 42))
      else $error("spurious result");

endmodule

@@ verif/pressure_temp_compensation_test.sv @@
// Self-checking testbench for the pressure/temperature compensation block.
// Depends on ptc_pkg and pressure_temp_compensation; predicts each result word in place.
`timescale 1ns / 1ps
module pressure_temp_compensation_test;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_start = 1'b0;
   logic                  req_busy;
   ptc_pkg::req_word_type req_word = '0;
   logic                  rsp_strobe;
   ptc_pkg::rsp_word_type rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [63:0]           csr_data = '0;

   ptc_pkg::req_word_type samples_pending[$];
   ptc_pkg::rsp_word_type readings_due[$];
   ptc_pkg::coeff_type    calib = '0;
   int                    mismatches = 0;
   int                    idle_left = 0;
   int                    gap_style = 0;

   pressure_temp_compensation u_dut (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] widen16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] shift_arith(input logic [31:0] x, input int unsigned n);
      return x[31] ? ~((~x) >> n) : (x >> n);
   endfunction

   function automatic ptc_pkg::rsp_word_type compensate(input ptc_pkg::req_word_type w,
                                                        input ptc_pkg::coeff_type c);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] up, ut, a, b, d, fine, q, p;
      ptc_pkg::rsp_word_type r;
      t1 = {16'd0, c.temp_coeffs[15:0]};
      t2 = widen16(c.temp_coeffs[31:16]);
      t3 = widen16(c.temp_coeffs[47:32]);
      p1 = {16'd0, c.press_low[15:0]};
      p2 = widen16(c.press_low[31:16]);
      p3 = widen16(c.press_low[47:32]);
      p4 = widen16(c.press_low[63:48]);
      p5 = widen16(c.press_high[15:0]);
      p6 = widen16(c.press_high[31:16]);
      p7 = widen16(c.press_high[47:32]);
      p8 = widen16(c.press_high[63:48]);
      p9 = widen16(c.press_nine);
      up = {12'd0, w.press_msb, w.press_lsb, w.press_xlsb[7:4]};
      ut = {12'd0, w.temp_msb, w.temp_lsb, w.temp_xlsb[7:4]};
      d = ((ut >> 3) - (t1 << 1)) * t2;
      a = shift_arith(d, 11);
      d = (ut >> 4) - t1;
      d = d * d;
      b = shift_arith(d, 12) * t3;
      b = shift_arith(b, 14);
      fine = a + b;
      d = fine * 32'd5 + 32'd128;
      r.temperature_centideg = shift_arith(d, 8);
      a = shift_arith(fine, 1) - 32'd64000;
      q = shift_arith(a, 2);
      d = q * q;
      b = shift_arith(d, 11) * p6;
      b = b + ((a * p5) << 1);
      b = shift_arith(b, 2) + (p4 << 16);
      d = p3 * shift_arith(q * q, 13);
      a = shift_arith(shift_arith(d, 3) + shift_arith(p2 * a, 1), 18);
      a = shift_arith((32'd32768 + a) * p1, 15);
      if (a == 32'd0) begin
         r.pressure_pa = 32'd0;
         r.pressure_invalid = 1'b1;
         return r;
      end
      p = ((32'd1048576 - up) - shift_arith(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) begin
         p = (p << 1) / a;
      end else begin
         p = (p / a) * 32'd2;
      end
      d = ((p >> 3) * (p >> 3)) >> 13;
      a = shift_arith(p9 * d, 12);
      b = shift_arith((p >> 2) * p8, 13);
      p = p + shift_arith(a + b + p7, 4);
      r.pressure_pa = p;
      r.pressure_invalid = 1'b0;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (gap_style == 0 || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request side: one word per handshake, the next one taken from the pending queue.
   always @(posedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_start && !req_busy) readings_due.push_back(compensate(req_word, calib));
         if (req_start && req_busy) begin
         end else if (idle_left > 0) begin
            idle_left = idle_left - 1;
            req_start <= 1'b0;
         end else if (samples_pending.size() > 0) begin
            req_word <= samples_pending.pop_front();
            req_start <= 1'b1;
            idle_left = pick_gap();
         end else begin
            req_start <= 1'b0;
         end
      end
   end

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin
      ptc_pkg::rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (readings_due.size() == 0) begin
            report("unexpected word", 32'd0, rsp_word.pressure_pa);
         end else begin
            want = readings_due.pop_front();
            if (rsp_word.temperature_centideg !== want.temperature_centideg)
               report("temperature", want.temperature_centideg, rsp_word.temperature_centideg);
            if (rsp_word.pressure_pa !== want.pressure_pa)
               report("pressure", want.pressure_pa, rsp_word.pressure_pa);
            if (rsp_word.pressure_invalid !== want.pressure_invalid)
               report("invalid flag", {31'd0, want.pressure_invalid},
                      {31'd0, rsp_word.pressure_invalid});
         end
      end
   end

   task automatic write_csr(input ptc_pkg::csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ptc_pkg::CSR_TEMP_COEFFS: calib.temp_coeffs = value[47:0];
         ptc_pkg::CSR_PRESS_LOW:   calib.press_low = value;
         ptc_pkg::CSR_PRESS_HIGH:  calib.press_high = value;
         ptc_pkg::CSR_PRESS_NINE:  calib.press_nine = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_calib(input int c[12]);
      write_csr(ptc_pkg::CSR_TEMP_COEFFS,
                {16'($urandom()), 16'(c[2]), 16'(c[1]), 16'(c[0])});
      write_csr(ptc_pkg::CSR_PRESS_LOW, {16'(c[6]), 16'(c[5]), 16'(c[4]), 16'(c[3])});
      write_csr(ptc_pkg::CSR_PRESS_HIGH, {16'(c[10]), 16'(c[9]), 16'(c[8]), 16'(c[7])});
      write_csr(ptc_pkg::CSR_PRESS_NINE, {$urandom(), 16'($urandom()), 16'(c[11])});
   endtask

   function automatic ptc_pkg::req_word_type make_sample(input logic [19:0] up,
                                                         input logic [19:0] ut);
      ptc_pkg::req_word_type w;
      w = {up[19:4], up[3:0], 4'($urandom()), ut[19:4], ut[3:0], 4'($urandom())};
      return w;
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (samples_pending.size() > 0 || readings_due.size() > 0 || req_start);
      repeat (50) @(posedge clock);
   endtask

   task automatic queue_directed();
      samples_pending.push_back('0);
      samples_pending.push_back('1);
      samples_pending.push_back(make_sample(20'd415148, 20'd519888));
      samples_pending.push_back({8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00});
      samples_pending.push_back({8'h65, 8'h5A, 8'hCF, 8'h7E, 8'hED, 8'h0F});
      samples_pending.push_back({8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
      samples_pending.push_back({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
      samples_pending.push_back({8'h80, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00});
      samples_pending.push_back({8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00});
      samples_pending.push_back({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0});
      samples_pending.push_back(make_sample(20'd300000, 20'd450000));
   endtask

   initial begin
      int nominal[12];
      int set[12];
      int kind;
      nominal = '{27504, 26435, -1000, 36477, -10685, 3024, 2855, 140, -7,
                  15500, -14600, 6000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Coefficients still zero after reset, so every pressure is invalid.
      gap_style = 0;
      queue_directed();
      drain();

      load_calib(nominal);
      gap_style = 1;
      queue_directed();
      drain();

      set = '{65535, 32767, 32767, 65535, 32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767};
      load_calib(set);
      queue_directed();
      drain();

      set = '{0, -32768, -32768, 1, -32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768};
      load_calib(set);
      gap_style = 0;
      queue_directed();
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         kind = phase % 4;
         for (int i = 0; i < 12; i++) begin
            case (kind)
               0: set[i] = nominal[i] + $urandom_range(0, 400) - 200;
               1, 3: set[i] = int'($urandom_range(0, 65535));
               default: set[i] = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            endcase
         end
         if (kind == 3) set[3] = 0;
         load_calib(set);
         gap_style = (phase % 3 == 2) ? 0 : 1;
         for (int n = 0; n < 180; n++) begin
            if ($urandom_range(0, 1) != 0)
               samples_pending.push_back(make_sample(20'($urandom_range(250000, 600000)),
                                                     20'($urandom_range(400000, 600000))));
            else
               samples_pending.push_back(
                  ptc_pkg::req_word_type'({$urandom(), 16'($urandom())}));
         end
         drain();
      end

      if (mismatches == 0 && readings_due.size() == 0) begin
         $display("pressure_temp_compensation regression: pass");
      end else begin
         $display("pressure_temp_compensation regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("pressure_temp_compensation regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
design/ptc_pkg.sv
design/ptc_front.sv
design/ptc_divider.sv
design/ptc_back.sv
design/pressure_temp_compensation.sv
verif/pressure_temp_compensation_test.sv
